@@ sv/cbq_pkg.sv @@
// ============================================================================
// Cascaded biquad package
// Shared constants, coefficient table and handshake types for the cascaded
// direct form II biquad filter.
// ============================================================================
`default_nettype none

package cbq_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int SIG_FRAC_BITS     = 16;
    localparam int TABLE_FRAC_BITS   = 30;
    localparam int COEF_W            = 32;
    localparam int FIXED_SECTIONS    = 3;
    localparam int COEFS_PER_SECTION = 5;
    localparam int CFG_W             = 2;

    // coefficient slots within a section
    localparam int SLOT_NA2 = 0;
    localparam int SLOT_B2  = 1;
    localparam int SLOT_NA1 = 2;
    localparam int SLOT_B1  = 3;
    localparam int SLOT_B0  = 4;

    // Q1.30 entries, per section: -a2, b2, -a1, b1, b0
    localparam logic signed [COEF_W-1:0] FIXED_COEFS [FIXED_SECTIONS*COEFS_PER_SECTION] = '{
        -32'sd1072233537, 32'sd231534295, 32'sd2145116790, -32'sd461419155, 32'sd231534295,
        -32'sd1066314189, 32'sd230574075, 32'sd2139387623, -32'sd460830000, 32'sd230574075,
        -32'sd1054220872, 32'sd229272523, 32'sd2127730120, -32'sd458316145, 32'sd229272523
    };

    // control bits that travel with a word from one section to the next
    typedef struct packed {
        logic valid;
        logic flag;
    } link_ctl_t;

    // Table entry brought to frac_bits fraction bits, round half up.
    // Sections past the fixed ones pass the signal through unchanged.
    function automatic logic signed [COEF_W-1:0] coef_scaled(input int section,
                                                             input int slot,
                                                             input int frac_bits);
        logic signed [63:0] v;
        int                 s;
        if (section < FIXED_SECTIONS) begin
            v = 64'(FIXED_COEFS[section*COEFS_PER_SECTION + slot]);
        end else if (slot == SLOT_B0) begin
            v = 64'sd1 <<< TABLE_FRAC_BITS;
        end else begin
            v = '0;
        end
        s = TABLE_FRAC_BITS - frac_bits;
        if (s > 0) begin
            v = (v + (64'sd1 <<< (s - 1))) >>> s;
        end
        return v[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/cbq_cell.sv @@
// ============================================================================
// Biquad section cell
// One direct form II section: holds its two delays, forms the delay products
// on a 33x32 multiplier while the upstream word is on its way, then finishes
// w and y once the input word arrives and hands y to the next cell.
// ============================================================================
`default_nettype none

module cbq_cell #(
    parameter int SECTION_INDEX  = 0,
    parameter int COEF_FRAC_BITS = 30,
    parameter int DELAY_WIDTH    = 48
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire cbq_pkg::link_ctl_t       x_ctl,
    input  wire logic signed [DELAY_WIDTH-1:0] x_data,
    output cbq_pkg::link_ctl_t            y_ctl,
    output logic signed [DELAY_WIDTH-1:0] y_data
);

    localparam int ACC_W   = DELAY_WIDTH + 34;
    localparam int CHUNK_W = 32;
    localparam int PROD_W  = CHUNK_W + 1 + cbq_pkg::COEF_W;

    localparam logic signed [cbq_pkg::COEF_W-1:0] C_NA2 =
        cbq_pkg::coef_scaled(SECTION_INDEX, cbq_pkg::SLOT_NA2, COEF_FRAC_BITS);
    localparam logic signed [cbq_pkg::COEF_W-1:0] C_B2 =
        cbq_pkg::coef_scaled(SECTION_INDEX, cbq_pkg::SLOT_B2, COEF_FRAC_BITS);
    localparam logic signed [cbq_pkg::COEF_W-1:0] C_NA1 =
        cbq_pkg::coef_scaled(SECTION_INDEX, cbq_pkg::SLOT_NA1, COEF_FRAC_BITS);
    localparam logic signed [cbq_pkg::COEF_W-1:0] C_B1 =
        cbq_pkg::coef_scaled(SECTION_INDEX, cbq_pkg::SLOT_B1, COEF_FRAC_BITS);
    localparam logic signed [cbq_pkg::COEF_W-1:0] C_B0 =
        cbq_pkg::coef_scaled(SECTION_INDEX, cbq_pkg::SLOT_B0, COEF_FRAC_BITS);

    // rounding half is preloaded into both accumulators
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [DELAY_WIDTH-1:0] D_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_WIDTH-1:0] D_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};

    // delay product steps, two chunks each
    localparam logic [1:0] PP_W2_NA2 = 2'd0;
    localparam logic [1:0] PP_W1_NA1 = 2'd1;
    localparam logic [1:0] PP_W2_B2  = 2'd2;
    localparam logic [1:0] PP_W1_B1  = 2'd3;

    localparam logic [2:0] PRE_LAST = 3'd7;

    typedef enum logic [5:0] {
        CS_IDLE = 6'b000001,
        CS_PRE  = 6'b000010,
        CS_WAIT = 6'b000100,
        CS_WSUM = 6'b001000,
        CS_YMUL = 6'b010000,
        CS_YSUM = 6'b100000
    } cell_state_t;

    cell_state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic signed [DELAY_WIDTH-1:0] w1_reg, w2_reg;
    logic signed [DELAY_WIDTH-1:0] x_reg;
    logic                          xflag_reg;
    logic                          have_x_reg;
    logic signed [ACC_W-1:0]       acc_w_reg, acc_y_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          pv_reg, pto_y_reg, phi_reg;
    cbq_pkg::link_ctl_t            y_ctl_reg;
    logic signed [DELAY_WIDTH-1:0] y_data_reg;

    logic                               issue;
    logic signed [DELAY_WIDTH-1:0]      op_data;
    logic signed [cbq_pkg::COEF_W-1:0]  op_coef;
    logic                               op_to_y;
    logic signed [63:0]                 op_wide;
    logic signed [CHUNK_W:0]            op_chunk;
    logic signed [PROD_W-1:0]           prod;
    logic signed [ACC_W-1:0]            term;
    logic signed [ACC_W-1:0]            rs_in, rs_sh;
    logic                               rs_ovf;
    logic signed [DELAY_WIDTH-1:0]      rs_val;
    logic                               x_take;

    // ---------------- multiplier operand select ----------------
    assign issue = (state_reg == CS_PRE) || (state_reg == CS_YMUL);

    always_comb begin
        op_data = w1_reg;
        op_coef = C_B0;
        op_to_y = 1'b1;
        if (state_reg == CS_PRE) begin
            case (cnt_reg[2:1])
                PP_W2_NA2: begin
                    op_data = w2_reg;
                    op_coef = C_NA2;
                    op_to_y = 1'b0;
                end
                PP_W1_NA1: begin
                    op_data = w1_reg;
                    op_coef = C_NA1;
                    op_to_y = 1'b0;
                end
                PP_W2_B2: begin
                    op_data = w2_reg;
                    op_coef = C_B2;
                    op_to_y = 1'b1;
                end
                PP_W1_B1: begin
                    op_data = w1_reg;
                    op_coef = C_B1;
                    op_to_y = 1'b1;
                end
                default: begin
                    op_data = w1_reg;
                    op_coef = C_B1;
                    op_to_y = 1'b1;
                end
            endcase
        end
    end

    // low chunk unsigned, high chunk signed
    assign op_wide  = 64'(op_data);
    assign op_chunk = cnt_reg[0] ? {op_wide[63], op_wide[63:CHUNK_W]}
                                 : {1'b0, op_wide[CHUNK_W-1:0]};
    assign prod     = op_chunk * op_coef;

    assign term = phi_reg ? (ACC_W'(prod_reg) <<< CHUNK_W) : ACC_W'(prod_reg);

    // ---------------- shared round and saturate ----------------
    assign rs_in  = (state_reg == CS_WSUM)
                  ? acc_w_reg + (ACC_W'(x_reg) <<< COEF_FRAC_BITS)
                  : acc_y_reg;
    assign rs_sh  = rs_in >>> COEF_FRAC_BITS;
    assign rs_ovf = ~((&rs_sh[ACC_W-1:DELAY_WIDTH-1]) | ~(|rs_sh[ACC_W-1:DELAY_WIDTH-1]));
    assign rs_val = rs_ovf ? (rs_sh[ACC_W-1] ? D_MIN : D_MAX) : rs_sh[DELAY_WIDTH-1:0];

    // take the upstream word only while this cell works on the current sample
    assign x_take = x_ctl.valid && ((state_reg != CS_IDLE) || start);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    state_next = CS_PRE;
                    cnt_next   = '0;
                end
            end
            CS_PRE: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == PRE_LAST) begin
                    state_next = CS_WAIT;
                end
            end
            CS_WAIT: begin
                if (have_x_reg && !pv_reg) begin
                    state_next = CS_WSUM;
                end
            end
            CS_WSUM: begin
                state_next = CS_YMUL;
                cnt_next   = '0;
            end
            CS_YMUL: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg[0]) begin
                    state_next = CS_YSUM;
                end
            end
            CS_YSUM: begin
                if (!pv_reg) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CS_IDLE;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            have_x_reg <= 1'b0;
            y_ctl_reg  <= '0;
            w1_reg     <= '0;
            w2_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pv_reg          <= issue;
            y_ctl_reg.valid <= (state_reg == CS_YSUM) && !pv_reg;
            if (x_take) begin
                have_x_reg <= 1'b1;
            end else if (state_reg == CS_WSUM) begin
                have_x_reg <= 1'b0;
            end
            if (state_reg == CS_WSUM) begin
                w2_reg <= w1_reg;
                w1_reg <= rs_val;
            end
            if ((state_reg == CS_YSUM) && !pv_reg) begin
                y_ctl_reg.flag  <= xflag_reg | rs_ovf;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        prod_reg  <= prod;
        pto_y_reg <= op_to_y;
        phi_reg   <= cnt_reg[0];
        if (x_take) begin
            x_reg     <= x_data;
            xflag_reg <= x_ctl.flag;
        end else if (state_reg == CS_WSUM) begin
            xflag_reg <= xflag_reg | rs_ovf;
        end
        if ((state_reg == CS_IDLE) && start) begin
            acc_w_reg <= ACC_HALF;
            acc_y_reg <= ACC_HALF;
        end else if (pv_reg) begin
            if (pto_y_reg) begin
                acc_y_reg <= acc_y_reg + term;
            end else begin
                acc_w_reg <= acc_w_reg + term;
            end
        end
        if ((state_reg == CS_YSUM) && !pv_reg) begin
            y_data_reg <= rs_val;
        end
    end

    assign y_ctl  = y_ctl_reg;
    assign y_data = y_data_reg;

endmodule

`default_nettype wire

@@ sv/cascaded_biquad_iir_filter_unit.sv @@
// ============================================================================
// Cascaded biquad IIR filter unit
// Usage:
//   s_valid/s_ready/s_sample_in take one signed 16-bit sample per word.
//   m_valid/m_ready/m_sample_out/m_saturated return one filtered sample per
//   input word, rounded half up and saturated to 16 bits; m_saturated is set
//   when any section value or the output clipped on that sample.
//   cfg_valid/cfg_ready/cfg_sections_in_use set how many sections run (0 acts
//   as 1, values above SECTIONS act as SECTIONS). Write it only while idle.
//   A new sample is taken only after the result of the last one is parked in
//   the output register, so samples do not overlap in the sections.
//   Each cell has one 33x32 multiplier: eight delay-product passes run in all
//   cells in use at once, then each section waits on the previous y and works
//   out w, its b0 product and y.
//   s_ready is high only while no sample is in flight. A finished word waits
//   in the output register while a new sample runs; if the receiver still
//   stalls when the next result is done, that result holds until m_ready.
//   Reset (aresetn low, synchronous) clears all section delays and sets
//   sections_in_use to 3.
// ============================================================================
`default_nettype none

module cascaded_biquad_iir_filter_unit #(
    parameter int SECTIONS       = 3,
    parameter int COEF_FRAC_BITS = 30,
    parameter int DELAY_WIDTH    = 48
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire logic signed [cbq_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic signed [cbq_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_saturated,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [cbq_pkg::CFG_W-1:0]              cfg_sections_in_use
);

    localparam int SW = cbq_pkg::SAMPLE_W;
    localparam logic [cbq_pkg::CFG_W-1:0] CFG_RESET = 2'd3;
    localparam logic signed [DELAY_WIDTH:0] OUT_HALF =
        (DELAY_WIDTH+1)'(1) <<< (cbq_pkg::SIG_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_OUT  = 3'b100
    } top_state_t;

    top_state_t                    state_reg;
    logic [cbq_pkg::CFG_W-1:0]     sections_reg;
    logic [cbq_pkg::CFG_W-1:0]     n_reg;
    logic [SECTIONS-1:0]           start_reg;
    logic signed [DELAY_WIDTH-1:0] x0_reg;
    logic signed [DELAY_WIDTH-1:0] ylast_reg;
    logic                          yflag_reg;
    logic                          m_valid_reg;
    logic signed [SW-1:0]          m_sample_reg;
    logic                          m_sat_reg;

    cbq_pkg::link_ctl_t            link_ctl  [SECTIONS+1];
    logic signed [DELAY_WIDTH-1:0] link_data [SECTIONS+1];

    logic                          s_take;
    logic [cbq_pkg::CFG_W-1:0]     n_eff;
    logic [SECTIONS-1:0]           start_next;
    cbq_pkg::link_ctl_t            last_ctl;
    logic signed [DELAY_WIDTH-1:0] last_data;
    logic [SECTIONS-1:0]           done_vec;
    logic signed [DELAY_WIDTH:0]   o_sum, o_sh;
    logic                          o_ovf;
    logic signed [SW-1:0]          o_val;
    logic                          out_load;

    assign s_ready   = (state_reg == T_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // clamp the section count to 1..SECTIONS
    always_comb begin
        n_eff = sections_reg;
        if (sections_reg == '0) begin
            n_eff = cbq_pkg::CFG_W'(1);
        end
        if (int'(n_eff) > SECTIONS) begin
            n_eff = cbq_pkg::CFG_W'(SECTIONS);
        end
        for (int k = 0; k < SECTIONS; k++) begin
            start_next[k] = (k < int'(n_eff));
        end
    end

    // ---------------- section chain ----------------
    assign link_ctl[0]  = '{valid: start_reg[0], flag: 1'b0};
    assign link_data[0] = x0_reg;

    for (genvar g = 0; g < SECTIONS; g++) begin : g_cell
        cbq_cell #(
            .SECTION_INDEX (g),
            .COEF_FRAC_BITS(COEF_FRAC_BITS),
            .DELAY_WIDTH   (DELAY_WIDTH)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .start  (start_reg[g]),
            .x_ctl  (link_ctl[g]),
            .x_data (link_data[g]),
            .y_ctl  (link_ctl[g+1]),
            .y_data (link_data[g+1])
        );
        assign done_vec[g] = link_ctl[g+1].valid;
    end

    // pick the last section in use
    always_comb begin
        last_ctl  = '0;
        last_data = '0;
        for (int k = 0; k < SECTIONS; k++) begin
            if (k == int'(n_reg) - 1) begin
                last_ctl  = link_ctl[k+1];
                last_data = link_data[k+1];
            end
        end
    end

    // ---------------- output rounding ----------------
    assign o_sum = (DELAY_WIDTH+1)'(ylast_reg) + OUT_HALF;
    assign o_sh  = o_sum >>> cbq_pkg::SIG_FRAC_BITS;
    assign o_ovf = ~((&o_sh[DELAY_WIDTH:SW-1]) | ~(|o_sh[DELAY_WIDTH:SW-1]));
    assign o_val = o_ovf ? (o_sh[DELAY_WIDTH] ? S_MIN : S_MAX) : o_sh[SW-1:0];

    assign out_load = (state_reg == T_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            sections_reg <= CFG_RESET;
            start_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // start pulses for one cycle, only on an accepted sample
            start_reg <= s_take ? start_next : '0;
            if (cfg_valid && cfg_ready) begin
                sections_reg <= cfg_sections_in_use;
            end
            case (state_reg)
                T_IDLE: begin
                    if (s_take) begin
                        state_reg <= T_RUN;
                    end
                end
                T_RUN: begin
                    if (last_ctl.valid) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_load) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            n_reg  <= n_eff;
            x0_reg <= DELAY_WIDTH'(s_sample_in) <<< cbq_pkg::SIG_FRAC_BITS;
        end
        if ((state_reg == T_RUN) && last_ctl.valid) begin
            ylast_reg <= last_data;
            yflag_reg <= last_ctl.flag;
        end
        if (out_load) begin
            m_sample_reg <= o_val;
            m_sat_reg    <= yflag_reg | o_ovf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_saturated  = m_sat_reg;

    // ---------------- assertions ----------------
    a_one_cell_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one section finished in the same cycle");

    a_done_while_run: assert property (@(posedge aclk) disable iff (!aresetn)
        last_ctl.valid |-> (state_reg == T_RUN))
        else $error("last section finished outside of a run");

    a_start_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (|start_reg) |-> $past(s_valid && s_ready))
        else $error("section start without an accepted sample");

endmodule

`default_nettype wire
